/* hdl/hcd_pkg.sv */
// Shared constants for the Harris corner detector.
// No dependencies; imported by the top level.
package hcd_pkg;

    // result field widths
    localparam int RESP_W = 54;
    localparam int THR_W  = 53;
    localparam int CFG_W  = 53;
    localparam int POS_W  = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_K      = 2'd2;
    localparam logic [1:0] CFG_THR    = 2'd3;

    // register defaults
    localparam logic [9:0]       WIDTH_RST  = 10'd500;
    localparam logic [12:0]      HEIGHT_RST = 13'd500;
    localparam logic [9:0]       K_RST      = 10'd20;
    localparam logic [THR_W-1:0] THR_RST    = 53'd26;

    localparam logic [12:0] ROW_SAT    = 13'd8191;
    localparam int          MAX_HEIGHT = 4096;

endpackage

/* hdl/hcd_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module hcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hdl/harris_corner_detector.sv */
// Harris corner detector top level: sequencer, window arithmetic, decision.
// Depends on hcd_pkg and hcd_ram.
//
// One gradient pixel is taken per transfer on the s_ side and one decision
// comes out per transfer on the m_ side, for the pixel 2*width+2 transfers
// back. Each pixel runs through an eight-step sequence: line memory read,
// column products, window sums, three multiply/accumulate steps for det and
// k*trace^2, response write-back, and output load; the next pixel is taken
// once the output is loaded. Two line memories (gradients and responses, one
// entry per column holding the two previous rows) carry the row history and
// need no clearing. Flush a frame with 2*width+2 padding transfers.
module harris_corner_detector
    import hcd_pkg::*;
#(
    parameter int MAX_WIDTH = 512,
    parameter int GRAD_BITS = 12
) (
    input  logic aclk,
    input  logic aresetn,
    // tdata: grad_x, grad_y (lowest bits first), zero padded
    input  logic [((2*GRAD_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: frame_start
    input  logic                             s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata: out_valid, is_corner, response (lowest bits first)
    output logic [55:0]                      m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data
);
    localparam int G   = GRAD_BITS;
    localparam int GE  = 2*G;            // one gradient pair
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CSW = 2*G + 2;        // column sum
    localparam int SW  = 2*G + 4;        // window sum
    localparam int KW  = 2*SW + 1;
    localparam int XW  = (2*SW + 2 > RESP_W) ? 2*SW + 2 : RESP_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_KT   = 3'd4;
    localparam logic [2:0] ST_KSUM = 3'd5;
    localparam logic [2:0] ST_RESP = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    typedef struct packed {
        logic signed [CSW-1:0] xx;
        logic signed [CSW-1:0] yy;
        logic signed [CSW-1:0] xy;
    } csum_t;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [9:0]       width_reg;
    logic [12:0]      height_reg;
    logic [9:0]       k_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            k_reg      <= K_RST;
            thr_reg    <= THR_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[9:0];
                CFG_HEIGHT: height_reg <= cfg_data[12:0];
                CFG_K:      k_reg      <= cfg_data[9:0];
                CFG_THR:    thr_reg    <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // position of the incoming pixel
    logic [AW-1:0]           col_cnt_reg;
    logic [12:0]             row_cnt_reg;
    logic signed [POS_W-1:0] eff_w, eff_h, col_s, row_s, jr, jc, dr;
    logic [AW-1:0]           col_now;
    logic [12:0]             row_now;
    logic                    resp_ok_now, dec_ok_now, accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (width_reg < 10'd3) begin
            eff_w = POS_W'(3);
        end else if (POS_W'(width_reg) > POS_W'(MAX_WIDTH)) begin
            eff_w = POS_W'(MAX_WIDTH);
        end else begin
            eff_w = POS_W'(width_reg);
        end
        if (height_reg < 13'd3) begin
            eff_h = POS_W'(3);
        end else if (POS_W'(height_reg) > POS_W'(MAX_HEIGHT)) begin
            eff_h = POS_W'(MAX_HEIGHT);
        end else begin
            eff_h = POS_W'(height_reg);
        end
        col_now = s_tuser ? '0 : col_cnt_reg;
        row_now = s_tuser ? '0 : row_cnt_reg;
        col_s   = POS_W'(col_now);
        row_s   = POS_W'(row_now);
        if (col_s >= 1) begin
            jr = row_s - POS_W'(1);
            jc = col_s - POS_W'(1);
        end else begin
            jr = row_s - POS_W'(2);
            jc = eff_w - POS_W'(1);
        end
        resp_ok_now = (jr >= 1) && (jr <= eff_h - 2) && (jc >= 1) && (jc <= eff_w - 2);
        dr = (col_s >= 2) ? row_s - POS_W'(2) : row_s - POS_W'(3);
        dec_ok_now = (dr >= 0) && (dr < eff_h);
    end

    logic [AW-1:0]        col_reg;
    logic                 resp_ok_reg, dec_ok_reg;
    logic signed [G-1:0]  gx_reg, gy_reg;

    // counters advance on each accepted transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            if (col_s + 1 >= eff_w) begin
                col_cnt_reg <= '0;
                if (row_now < ROW_SAT) begin
                    row_cnt_reg <= row_now + 13'd1;
                end else begin
                    row_cnt_reg <= row_now;
                end
            end else begin
                col_cnt_reg <= AW'(col_s + 1);
                row_cnt_reg <= row_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg     <= col_now;
            resp_ok_reg <= resp_ok_now;
            dec_ok_reg  <= dec_ok_now;
            gx_reg      <= s_tdata[G-1:0];
            gy_reg      <= s_tdata[2*G-1:G];
        end
    end

    // line memories: entry = {older row, newer row}
    logic [AW-1:0]         ram_addr;
    logic [2*GE-1:0]       g_rd, g_wr;
    logic [2*RESP_W-1:0]   r_rd, r_rd_reg, r_wr;
    logic                  g_we, r_we;
    logic signed [RESP_W-1:0] resp_new;

    assign ram_addr = accept ? col_now : col_reg;
    assign g_we     = (state_reg == ST_RD);
    assign r_we     = (state_reg == ST_RESP);
    assign g_wr     = {g_rd[GE-1:0], gx_reg, gy_reg};
    assign r_wr     = {r_rd_reg[RESP_W-1:0], resp_new};

    hcd_ram #(.WIDTH(2*GE), .DEPTH(MAX_WIDTH)) u_grad_ram (
        .aclk(aclk), .we(g_we), .addr(ram_addr), .wdata(g_wr), .rdata(g_rd)
    );

    hcd_ram #(.WIDTH(2*RESP_W), .DEPTH(MAX_WIDTH)) u_resp_ram (
        .aclk(aclk), .we(r_we), .addr(ram_addr), .wdata(r_wr), .rdata(r_rd)
    );

    // products of the new window column (top, middle, bottom)
    logic signed [G-1:0]  cgx [3];
    logic signed [G-1:0]  cgy [3];
    csum_t                cs_new;

    always_comb begin
        cgx[0] = g_rd[2*GE-1:GE+G];
        cgy[0] = g_rd[GE+G-1:GE];
        cgx[1] = g_rd[GE-1:G];
        cgy[1] = g_rd[G-1:0];
        cgx[2] = gx_reg;
        cgy[2] = gy_reg;
        cs_new = '0;
        for (int i = 0; i < 3; i++) begin
            cs_new.xx = cs_new.xx + CSW'(cgx[i] * cgx[i]);
            cs_new.yy = cs_new.yy + CSW'(cgy[i] * cgy[i]);
            cs_new.xy = cs_new.xy + CSW'(cgx[i] * cgy[i]);
        end
    end

    csum_t cs_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                cs_reg[i] <= '0;
            end
        end else if (state_reg == ST_RD) begin
            cs_reg[0] <= cs_reg[1];
            cs_reg[1] <= cs_reg[2];
            cs_reg[2] <= cs_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD) begin
            r_rd_reg <= r_rd;
        end
    end

    // window sums and the response arithmetic
    logic signed [SW-1:0]   sxx_reg, syy_reg, sxy_reg;
    logic [SW-1:0]          tr_reg;
    logic signed [2*SW-1:0] p1_reg, p2_reg;
    logic [2*SW-1:0]        tr2_reg;
    logic signed [2*SW:0]   det_reg;
    logic [SW+9:0]          ktl_reg, kth_reg;
    logic [KW-1:0]          kt_reg;
    logic [2*SW+10:0]       kt_full;
    logic signed [XW-1:0]   resp_x;

    assign kt_full = ((2*SW+11)'(kth_reg) << SW) + (2*SW+11)'(ktl_reg) + (2*SW+11)'(512);
    assign resp_x  = XW'(det_reg) - $signed(XW'(kt_reg));
    assign resp_new = resp_ok_reg ? resp_x[RESP_W-1:0] : '0;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_SUM: begin
                sxx_reg <= SW'(cs_reg[0].xx) + SW'(cs_reg[1].xx) + SW'(cs_reg[2].xx);
                syy_reg <= SW'(cs_reg[0].yy) + SW'(cs_reg[1].yy) + SW'(cs_reg[2].yy);
                sxy_reg <= SW'(cs_reg[0].xy) + SW'(cs_reg[1].xy) + SW'(cs_reg[2].xy);
                tr_reg  <= SW'(cs_reg[0].xx) + SW'(cs_reg[1].xx) + SW'(cs_reg[2].xx)
                         + SW'(cs_reg[0].yy) + SW'(cs_reg[1].yy) + SW'(cs_reg[2].yy);
            end
            ST_MUL: begin
                p1_reg  <= sxx_reg * syy_reg;
                p2_reg  <= sxy_reg * sxy_reg;
                tr2_reg <= tr_reg * tr_reg;
            end
            ST_KT: begin
                det_reg <= (2*SW+1)'(p1_reg) - (2*SW+1)'(p2_reg);
                ktl_reg <= tr2_reg[SW-1:0] * k_reg;
                kth_reg <= tr2_reg[2*SW-1:SW] * k_reg;
            end
            ST_KSUM: begin
                kt_reg <= kt_full[2*SW+10:10];
            end
            default: ;
        endcase
    end

    // response window, rows top to bottom, columns oldest to newest
    logic signed [RESP_W-1:0] rw_reg [3][3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rw_reg[i][j] <= '0;
                end
            end
        end else if (state_reg == ST_RESP) begin
            for (int i = 0; i < 3; i++) begin
                rw_reg[i][0] <= rw_reg[i][1];
                rw_reg[i][1] <= rw_reg[i][2];
            end
            rw_reg[0][2] <= r_rd_reg[2*RESP_W-1:RESP_W];
            rw_reg[1][2] <= r_rd_reg[RESP_W-1:0];
            rw_reg[2][2] <= resp_new;
        end
    end

    // extremum and threshold test on the window center
    logic is_max, is_min, corner;

    always_comb begin
        is_max = 1'b1;
        is_min = 1'b1;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(i == 1 && j == 1)) begin
                    if (rw_reg[1][1] < rw_reg[i][j]) is_max = 1'b0;
                    if (rw_reg[1][1] > rw_reg[i][j]) is_min = 1'b0;
                end
            end
        end
        corner = (is_max || is_min) &&
                 ($signed({rw_reg[1][1][RESP_W-1], rw_reg[1][1]}) >
                  $signed({2'b00, thr_reg}));
    end

    // output register
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic        out_load;

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg[0]    <= dec_ok_reg;
            m_data_reg[1]    <= dec_ok_reg && corner;
            m_data_reg[55:2] <= dec_ok_reg ? rw_reg[1][1] : '0;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_KT;
            ST_KT:   state_next = ST_KSUM;
            ST_KSUM: state_next = ST_RESP;
            ST_RESP: state_next = ST_OUT;
            ST_OUT:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule
